FILE: hw/rtl/sha256_pkg.sv
// shared constants and round functions for the sha-256 stream hasher
package sha256_pkg;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_W     = 512;
    localparam int unsigned FILL_W      = 6;
    localparam int unsigned ROUND_W     = 6;
    localparam int unsigned LEN_W       = 64;
    localparam int unsigned NUM_WORDS   = 8;
    localparam int unsigned NUM_ROUNDS  = 64;

    localparam logic [7:0]         PAD_BYTE   = 8'h80;
    localparam logic [FILL_W-1:0]  LEN_POS    = 6'd56;
    localparam logic [FILL_W-1:0]  LAST_POS   = 6'd63;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
    localparam logic [2:0]         LAST_INDEX = 3'd7;

    // round constants
    localparam logic [31:0] K_TABLE [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // initial chaining values
    localparam logic [31:0] H_INIT [NUM_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

FILE: hw/rtl/sha256_stream_hasher.sv
// sha-256 stream hasher: byte stream in, eight digest words out
// a message byte is taken while the block is idle; the byte that fills a 64-byte block
// starts 64 rounds of the shared round unit, then one chaining add
// end of message: the pad bytes, one or two compressions, then the
// eight digest words, one per cycle while the output side takes them
// reset is asynchronous active low: chaining words return to the initial
// values and the counters clear; the block is ready right after reset
module sha256_stream_hasher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: data_byte
    input  logic [sha256_pkg::IN_TDATA_W-1:0]    s_tdata,
    // s_tuser: byte_valid
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // m_tdata: digest_word [31:0], word_index [34:32], zero fill [39:35]
    output logic [sha256_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [LEN_W-1:0]       bits_reg, bits_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [WORD_W-1:0]      chain_reg [NUM_WORDS];
    logic [WORD_W-1:0]      chain_next [NUM_WORDS];
    logic [WORD_W-1:0]      v_reg [NUM_WORDS];
    logic [WORD_W-1:0]      v_next [NUM_WORDS];
    logic [BLOCK_W-1:0]     w_reg, w_next;
    logic [ROUND_W-1:0]     round_reg, round_next;
    logic                   pad_reg, pad_next;
    logic                   first_reg, first_next;
    logic                   lenph_reg, lenph_next;
    logic [2:0]             word_reg, word_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    logic                   push_en;
    logic [7:0]             push_byte;
    logic [WORD_W-1:0]      wv;
    logic [WORD_W-1:0]      t1;
    logic [WORD_W-1:0]      t2;

    // schedule taps: oldest word at the top of the window
    always_comb
    begin
        if (round_reg < 6'd16)
        begin
            wv = w_reg[511:480];
        end
        else
        begin
            wv = w_reg[511:480] + small_sigma0(w_reg[479:448]) + w_reg[223:192]
               + small_sigma1(w_reg[63:32]);
        end
        t1 = v_reg[7] + big_sigma1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
           + K_TABLE[round_reg] + wv;
        t2 = big_sigma0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        bits_next     = bits_reg;
        len_next      = len_reg;
        chain_next    = chain_reg;
        v_next        = v_reg;
        w_next        = w_reg;
        round_next    = round_reg;
        pad_next      = pad_reg;
        first_next    = first_reg;
        lenph_next    = lenph_reg;
        word_next     = word_reg;
        m_tvalid_next = m_tvalid_reg;
        push_en       = 1'b0;
        push_byte     = 8'h00;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        push_en   = 1'b1;
                        push_byte = s_tdata;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (s_tlast)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        lenph_next = 1'b0;
                        len_next   = s_tuser ? bits_reg + 64'd8 : bits_reg;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                v_next[7]  = v_reg[6];
                v_next[6]  = v_reg[5];
                v_next[5]  = v_reg[4];
                v_next[4]  = v_reg[3] + t1;
                v_next[3]  = v_reg[2];
                v_next[2]  = v_reg[1];
                v_next[1]  = v_reg[0];
                v_next[0]  = t1 + t2;
                w_next     = {w_reg[479:0], wv};
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                if (lenph_reg)
                begin
                    state_next    = ST_OUT;
                    m_tvalid_next = 1'b1;
                    word_next     = 3'd0;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (first_reg)
                begin
                    push_byte  = PAD_BYTE;
                    first_next = 1'b0;
                end
                else if (lenph_reg || fill_reg == LEN_POS)
                begin
                    push_byte  = len_reg[63:56];
                    len_next   = {len_reg[55:0], 8'h00};
                    lenph_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == LAST_INDEX)
                    begin
                        state_next    = ST_IDLE;
                        m_tvalid_next = 1'b0;
                        chain_next    = H_INIT;
                        bits_next     = '0;
                        fill_next     = '0;
                        pad_next      = 1'b0;
                        lenph_next    = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // byte into the block window; a full block starts the rounds
        if (push_en)
        begin
            w_next    = {w_reg[503:0], push_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == LAST_POS)
            begin
                state_next = ST_ROUND;
                round_next = '0;
                v_next     = chain_reg;
            end
        end
    end

    // state, counters and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            bits_reg     <= '0;
            chain_reg    <= H_INIT;
            round_reg    <= '0;
            pad_reg      <= 1'b0;
            first_reg    <= 1'b0;
            lenph_reg    <= 1'b0;
            word_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            chain_reg    <= chain_next;
            round_reg    <= round_next;
            pad_reg      <= pad_next;
            first_reg    <= first_next;
            lenph_reg    <= lenph_next;
            word_reg     <= word_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // working variables, schedule window and length shifter
    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        w_reg   <= w_next;
        len_reg <= len_next;
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, word_reg, chain_reg[word_reg]};
    assign m_tlast  = (word_reg == LAST_INDEX);

    // no new request taken while a digest is being sent
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while digest pending");

    // word index steps by one within a digest
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && m_tdata[34:32] == 3'($past(m_tdata[34:32]) + 3'd1)))
        else $error("digest word index skipped");

    // after the last word the block returns to ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("not ready after final digest word");

endmodule
